// File: rtl/core/svib_pkg.sv
// ----------------------------------------------------------------------------
// svib_pkg
// shared types and constants of the shadow volume index builder
// ----------------------------------------------------------------------------
package svib_pkg;

   localparam int MAX_VERTS_DEF  = 65536;
   localparam int MAX_FACES_DEF  = 65536;
   localparam int COUNT_BITS_DEF = 24;

   localparam int VERT_W  = 16;
   localparam int FACE_W  = 16;
   localparam int CODE_W  = 8;
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 17;
   localparam int SLOT_W  = 3;
   localparam int SUM_W   = 24;

   localparam int QUEUE_DEPTH = 2;

   // range compare width, holds any depth up to 2^24
   localparam int RANGE_W = 25;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_CULL_ENABLE_ADDR = 3'd0;

   localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CULL    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FACE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EDGE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CAP     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SUMMARY = 3'd5;

   localparam logic KIND_INDEX   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_CULL,
      OP_FACE,
      OP_EDGE,
      OP_CAP,
      OP_SUMMARY
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [FACE_W-1:0]   face_number;
      logic [VERT_W-1:0]   vert_a;
      logic [VERT_W-1:0]   vert_b;
      logic [VERT_W-1:0]   vert_c;
      logic                faces_away_not;
      logic [CODE_W-1:0]   cull_code;
      logic [FACE_W-1:0]   face_left;
      logic [FACE_W-1:0]   face_right;
      logic                va_ok;
      logic                vb_ok;
      logic                vc_ok;
      logic                fl_ok;
      logic                fr_ok;
   } item_type;

endpackage

// File: rtl/core/svib_req_if.sv
// ----------------------------------------------------------------------------
// svib_req_if
// command channel of the shadow volume index builder
// ----------------------------------------------------------------------------
interface svib_req_if
   import svib_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [FACE_W-1:0]   face_number;
   logic [VERT_W-1:0]   vert_a;
   logic [VERT_W-1:0]   vert_b;
   logic [VERT_W-1:0]   vert_c;
   logic                faces_away_not;
   logic [CODE_W-1:0]   cull_code;
   logic [FACE_W-1:0]   face_left;
   logic [FACE_W-1:0]   face_right;

   modport source (
      output valid, cmd, face_number, vert_a, vert_b, vert_c,
             faces_away_not, cull_code, face_left, face_right,
      input  ready
   );

   modport sink (
      input  valid, cmd, face_number, vert_a, vert_b, vert_c,
             faces_away_not, cull_code, face_left, face_right,
      output ready
   );
endinterface

// File: rtl/core/svib_rsp_if.sv
// ----------------------------------------------------------------------------
// svib_rsp_if
// result channel of the shadow volume index builder
// ----------------------------------------------------------------------------
interface svib_rsp_if
   import svib_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [INDEX_W-1:0]  index_value;
   logic [SLOT_W-1:0]   slot;
   logic                last;
   logic [SUM_W-1:0]    shadowing_faces;
   logic [SUM_W-1:0]    sil_index_count;
   logic [SUM_W-1:0]    total_index_count;
   logic                volume_empty;

   modport source (
      output valid, kind, index_value, slot, last, shadowing_faces,
             sil_index_count, total_index_count, volume_empty,
      input  ready
   );

   modport sink (
      input  valid, kind, index_value, slot, last, shadowing_faces,
             sil_index_count, total_index_count, volume_empty,
      output ready
   );
endinterface

// File: rtl/core/svib_front.sv
// ----------------------------------------------------------------------------
// svib_front
// accepts command transactions, decodes them and checks table ranges
// ----------------------------------------------------------------------------
module svib_front
   import svib_pkg::*;
#(
   parameter int MAX_VERTS = MAX_VERTS_DEF,
   parameter int MAX_FACES = MAX_FACES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   svib_req_if.sink       req_bus,
   output logic           item_valid,
   output item_type       item,
   input  logic           item_ready
);

   localparam logic [RANGE_W-1:0] VERT_LIMIT = RANGE_W'(MAX_VERTS);
   localparam logic [RANGE_W-1:0] FACE_LIMIT = RANGE_W'(MAX_FACES);

   logic      stage_valid_ff, stage_valid_in;
   item_type  stage_item_ff, stage_item_in;
   logic      take;
   item_type  dec;
   logic      face_ok;

   assign req_bus.ready = !stage_valid_ff || item_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      dec.face_number    = req_bus.face_number;
      dec.vert_a         = req_bus.vert_a;
      dec.vert_b         = req_bus.vert_b;
      dec.vert_c         = req_bus.vert_c;
      dec.faces_away_not = req_bus.faces_away_not;
      dec.cull_code      = req_bus.cull_code;
      dec.face_left      = req_bus.face_left;
      dec.face_right     = req_bus.face_right;
      dec.va_ok          = RANGE_W'(req_bus.vert_a) < VERT_LIMIT;
      dec.vb_ok          = RANGE_W'(req_bus.vert_b) < VERT_LIMIT;
      dec.vc_ok          = RANGE_W'(req_bus.vert_c) < VERT_LIMIT;
      dec.fl_ok          = RANGE_W'(req_bus.face_left) < FACE_LIMIT;
      dec.fr_ok          = RANGE_W'(req_bus.face_right) < FACE_LIMIT;
      face_ok            = RANGE_W'(req_bus.face_number) < FACE_LIMIT;
      unique case (req_bus.cmd)
         CMD_START:   dec.op = OP_START;
         CMD_CULL:    dec.op = dec.va_ok ? OP_CULL : OP_NONE;
         CMD_FACE:    dec.op = face_ok ? OP_FACE : OP_NONE;
         CMD_EDGE:    dec.op = OP_EDGE;
         CMD_CAP:     dec.op = face_ok ? OP_CAP : OP_NONE;
         CMD_SUMMARY: dec.op = OP_SUMMARY;
         default:     dec.op = OP_NONE;
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (item_ready) begin
         stage_valid_in = 1'b0;
      end
      if (take) begin
         stage_valid_in = 1'b1;
         stage_item_in  = dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

   assign item_valid = stage_valid_ff;
   assign item       = stage_item_ff;

endmodule

// File: rtl/core/svib_queue.sv
// ----------------------------------------------------------------------------
// svib_queue
// short queue of decoded items between front and back
// ----------------------------------------------------------------------------
module svib_queue
   import svib_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  item_type  in_item,
   output logic      in_ready,
   output logic      out_valid,
   output item_type  out_item,
   input  logic      out_ready
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/core/svib_back.sv
// ----------------------------------------------------------------------------
// svib_back
// executes decoded items: vertex and face tables, counters, index emission
// ----------------------------------------------------------------------------
module svib_back
   import svib_pkg::*;
#(
   parameter int MAX_VERTS  = MAX_VERTS_DEF,
   parameter int MAX_FACES  = MAX_FACES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cull_enable,
   input  logic      item_valid,
   input  item_type  item,
   output logic      item_ready,
   svib_rsp_if.source rsp_bus
);

   localparam int VAW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam int FAW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int VEXT_W = (VAW > VERT_W) ? VAW : VERT_W;
   localparam int FEXT_W = (FAW > FACE_W) ? FAW : FACE_W;
   localparam int CB     = COUNT_BITS;
   localparam logic [CB:0] COUNT_MAX = {1'b0, {CB{1'b1}}};
   localparam logic [32:0] SUM_MAX   = 33'h0FFFFFF;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CULL_B   = 8'b0000_0010,
      ST_CULL_C   = 8'b0000_0100,
      ST_CULL_END = 8'b0000_1000,
      ST_LOOK     = 8'b0001_0000,
      ST_EMIT     = 8'b0010_0000,
      ST_SUM_CALC = 8'b0100_0000,
      ST_SUM_OUT  = 8'b1000_0000
   } back_state_type;

   function automatic logic [VAW-1:0] vaddr(input logic [VERT_W-1:0] v);
      logic [VEXT_W-1:0] e;
      e = VEXT_W'(v);
      return e[VAW-1:0];
   endfunction

   function automatic logic [FAW-1:0] faddr(input logic [FACE_W-1:0] f);
      logic [FEXT_W-1:0] e;
      e = FEXT_W'(f);
      return e[FAW-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] cap24(input logic [CB-1:0] x);
      logic [32:0] e;
      e = 33'(x);
      return (e > SUM_MAX) ? {SUM_W{1'b1}} : e[SUM_W-1:0];
   endfunction

   // tables
   logic [CODE_W-1:0]     cull_mem   [MAX_VERTS];
   logic                  facing_mem [MAX_FACES];
   logic [3*VERT_W-1:0]   fvert_mem  [MAX_FACES];

   logic [CODE_W-1:0]     cull_rd_ff;
   logic                  facing_rd0_ff, facing_rd1_ff;
   logic [3*VERT_W-1:0]   fvert_rd_ff;

   logic [VAW-1:0]        cull_raddr;
   logic [FAW-1:0]        facing_raddr0, facing_raddr1;
   logic                  cull_we, facing_we, fvert_we;
   logic                  facing_wdata;

   back_state_type        state_ff, state_in;
   item_type              cur_ff, cur_in;
   logic [CODE_W-1:0]     acc_ff, acc_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [5:0][INDEX_W-1:0] words_ff, words_in;
   logic [CB-1:0]         shadow_ff, shadow_in;
   logic [CB-1:0]         edge_ff, edge_in;
   logic [CB-1:0]         six_ff, six_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [SUM_W-1:0]      rsp_faces_ff, rsp_faces_in;
   logic [SUM_W-1:0]      rsp_sil_ff, rsp_sil_in;
   logic [SUM_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  out_free;
   logic                  f1, f2, culled;
   logic [CODE_W-1:0]     cull_a, cull_b, cull_c;
   logic [CB:0]           edge_sum, total_sum;
   logic [CB+2:0]         prod6;
   logic [VERT_W-1:0]     i0, i1, i2;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      unique case (state_ff)
         ST_CULL_B: cull_raddr = vaddr(cur_ff.vert_b);
         ST_CULL_C: cull_raddr = vaddr(cur_ff.vert_c);
         default:   cull_raddr = vaddr(item.vert_a);
      endcase
      facing_raddr0 = (item.op == OP_CAP) ? faddr(item.face_number) : faddr(item.face_left);
      facing_raddr1 = faddr(item.face_right);
   end

   always_comb begin
      cull_a    = cur_ff.va_ok ? cull_rd_ff : '0;
      cull_b    = cur_ff.vb_ok ? cull_rd_ff : '0;
      cull_c    = cur_ff.vc_ok ? cull_rd_ff : '0;
      culled    = |(acc_ff & cull_c);
      f1        = cur_ff.fl_ok ? facing_rd0_ff : 1'b1;
      f2        = cur_ff.fr_ok ? facing_rd1_ff : 1'b1;
      i0        = fvert_rd_ff[VERT_W-1:0];
      i1        = fvert_rd_ff[2*VERT_W-1:VERT_W];
      i2        = fvert_rd_ff[3*VERT_W-1:2*VERT_W];
      edge_sum  = {1'b0, edge_ff} + (CB+1)'(6);
      prod6     = ((CB+3)'(shadow_ff) << 2) + ((CB+3)'(shadow_ff) << 1);
      total_sum = {1'b0, edge_ff} + {1'b0, six_ff};
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      words_in     = words_ff;
      shadow_in    = shadow_ff;
      edge_in      = edge_ff;
      six_in       = six_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_faces_in = rsp_faces_ff;
      rsp_sil_in   = rsp_sil_ff;
      rsp_total_in = rsp_total_ff;
      rsp_empty_in = rsp_empty_ff;
      item_ready   = 1'b0;
      cull_we      = 1'b0;
      facing_we    = 1'b0;
      facing_wdata = 1'b0;
      fvert_we     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               cur_in = item;
               unique case (item.op)
                  OP_START: begin
                     shadow_in = '0;
                     edge_in   = '0;
                  end
                  OP_CULL: begin
                     cull_we = 1'b1;
                  end
                  OP_FACE: begin
                     fvert_we = 1'b1;
                     if (item.faces_away_not) begin
                        facing_we    = 1'b1;
                        facing_wdata = 1'b1;
                     end else if (!cull_enable) begin
                        facing_we    = 1'b1;
                        facing_wdata = 1'b0;
                        if (shadow_ff != '1) begin
                           shadow_in = shadow_ff + 1'b1;
                        end
                     end else begin
                        state_in = ST_CULL_B;
                     end
                  end
                  OP_EDGE, OP_CAP: begin
                     state_in = ST_LOOK;
                  end
                  OP_SUMMARY: begin
                     state_in = ST_SUM_CALC;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CULL_B: begin
            acc_in   = cull_a;
            state_in = ST_CULL_C;
         end

         ST_CULL_C: begin
            acc_in   = acc_ff & cull_b;
            state_in = ST_CULL_END;
         end

         ST_CULL_END: begin
            facing_we    = 1'b1;
            facing_wdata = culled;
            if (!culled && shadow_ff != '1) begin
               shadow_in = shadow_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_LOOK: begin
            slot_in = '0;
            if (cur_ff.op == OP_EDGE) begin
               words_in[0] = {cur_ff.vert_a, 1'b0};
               words_in[1] = {cur_ff.vert_b, f1};
               words_in[2] = {cur_ff.vert_b, f2};
               words_in[3] = {cur_ff.vert_a, f2};
               words_in[4] = {cur_ff.vert_a, f1};
               words_in[5] = {cur_ff.vert_b, 1'b1};
               if (f1 != f2) begin
                  state_in = ST_EMIT;
                  edge_in  = (edge_sum > COUNT_MAX) ? '1 : edge_sum[CB-1:0];
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               words_in[0] = {i2, 1'b0};
               words_in[1] = {i1, 1'b0};
               words_in[2] = {i0, 1'b0};
               words_in[3] = {i0, 1'b1};
               words_in[4] = {i1, 1'b1};
               words_in[5] = {i2, 1'b1};
               state_in    = facing_rd0_ff ? ST_IDLE : ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_INDEX;
               rsp_index_in = words_ff[slot_ff];
               rsp_slot_in  = slot_ff;
               rsp_last_in  = slot_ff == SLOT_LAST;
               rsp_faces_in = '0;
               rsp_sil_in   = '0;
               rsp_total_in = '0;
               rsp_empty_in = 1'b0;
               slot_in      = slot_ff + 1'b1;
               if (slot_ff == SLOT_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SUM_CALC: begin
            six_in   = (prod6[CB+2:CB] != '0) ? '1 : prod6[CB-1:0];
            state_in = ST_SUM_OUT;
         end

         ST_SUM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SUMMARY;
               rsp_index_in = '0;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_faces_in = cap24(shadow_ff);
               rsp_sil_in   = cap24(edge_ff);
               rsp_total_in = cap24((total_sum > COUNT_MAX) ? '1 : total_sum[CB-1:0]);
               rsp_empty_in = shadow_ff == '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shadow_ff    <= '0;
         edge_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shadow_ff    <= shadow_in;
         edge_ff      <= edge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      slot_ff      <= slot_in;
      words_ff     <= words_in;
      six_ff       <= six_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_faces_ff <= rsp_faces_in;
      rsp_sil_ff   <= rsp_sil_in;
      rsp_total_ff <= rsp_total_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // vertex cull table
   always_ff @(posedge clock) begin
      if (cull_we) begin
         cull_mem[vaddr(item.vert_a)] <= item.cull_code;
      end
      cull_rd_ff <= cull_mem[cull_raddr];
   end

   // face facing table, one write and two read ports
   always_ff @(posedge clock) begin
      if (facing_we) begin
         facing_mem[faddr(cur_in.face_number)] <= facing_wdata;
      end
      facing_rd0_ff <= facing_mem[facing_raddr0];
      facing_rd1_ff <= facing_mem[facing_raddr1];
   end

   // face vertex table
   always_ff @(posedge clock) begin
      if (fvert_we) begin
         fvert_mem[faddr(item.face_number)] <= {item.vert_c, item.vert_b, item.vert_a};
      end
      fvert_rd_ff <= fvert_mem[faddr(item.face_number)];
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.kind              = rsp_kind_ff;
   assign rsp_bus.index_value       = rsp_index_ff;
   assign rsp_bus.slot              = rsp_slot_ff;
   assign rsp_bus.last              = rsp_last_ff;
   assign rsp_bus.shadowing_faces   = rsp_faces_ff;
   assign rsp_bus.sil_index_count   = rsp_sil_ff;
   assign rsp_bus.total_index_count = rsp_total_ff;
   assign rsp_bus.volume_empty      = rsp_empty_ff;

endmodule

// File: rtl/core/shadow_volume_index_builder.sv
// ----------------------------------------------------------------------------
// shadow_volume_index_builder
// builds stencil shadow volume index lists: silhouette quads and caps
//
//   channel   direction  transfer rule                 contents
//   req_bus   in         valid & ready                 command and its operands
//   rsp_bus   out        valid & ready                 index word or summary
//   csr_*     in         psel & penable & pwrite       cull_enable at offset 0
//
// a command passes a decode register, then waits in a two-entry queue for the
// sequencer. start, vertex cull and face loads end in ST_IDLE; an away face with
// culling on adds ST_CULL_B, _C and _END (three cull reads through one port).
// edges and caps add ST_LOOK and ST_EMIT (six index words), a summary ST_SUM_CALC
// and ST_SUM_OUT. the sequencer stalls only while the result register holds an
// unaccepted transaction. reset clears control and counters, not the tables.
// ----------------------------------------------------------------------------
module shadow_volume_index_builder
   import svib_pkg::*;
#(
   parameter int MAX_VERTS  = MAX_VERTS_DEF,
   parameter int MAX_FACES  = MAX_FACES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   svib_req_if.sink               req_bus,
   svib_rsp_if.source             rsp_bus,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic      cull_enable_ff, cull_enable_in;
   logic      csr_write;
   logic      fr_valid, fr_ready;
   item_type  fr_item;
   logic      bk_valid, bk_ready;
   item_type  bk_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_CULL_ENABLE_ADDR) ?
                       CSR_DATA_W'(cull_enable_ff) : '0;

   always_comb begin
      cull_enable_in = cull_enable_ff;
      if (csr_write && csr_paddr == CSR_CULL_ENABLE_ADDR) begin
         cull_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cull_enable_ff <= 1'b0;
      end else begin
         cull_enable_ff <= cull_enable_in;
      end
   end

   svib_front #(
      .MAX_VERTS (MAX_VERTS),
      .MAX_FACES (MAX_FACES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (fr_valid),
      .item       (fr_item),
      .item_ready (fr_ready)
   );

   svib_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_ready  (fr_ready),
      .out_valid (bk_valid),
      .out_item  (bk_item),
      .out_ready (bk_ready)
   );

   svib_back #(
      .MAX_VERTS  (MAX_VERTS),
      .MAX_FACES  (MAX_FACES),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cull_enable (cull_enable_ff),
      .item_valid  (bk_valid),
      .item        (bk_item),
      .item_ready  (bk_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule
